// ===== hw/rtl/bpmd_pkg.sv =====
// Shared types and constants of the balance PID motor drive.
`default_nettype none

package bpmd_pkg;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int SUM_W   = 32;
  localparam int CMP_W   = 10;
  localparam int MAG_W   = 7;
  localparam int DIFF_W  = ANGLE_W + 1;
  localparam int PROD_P_W = GAIN_W + 1 + ANGLE_W;
  localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W   = PROD_I_W + 1;
  localparam int FRAC_W  = 16;
  localparam int QUOT_W  = ACC_W - FRAC_W;

  // Control law constants.
  localparam int SEPARATION_LIMIT = 18;
  localparam int SEPARATION_LOWER = SEPARATION_LIMIT - SEPARATION_LIMIT / 10;
  localparam int DRIVE_LIMIT = 400;
  localparam int OFFSET_A = 180;
  localparam int OFFSET_B = 179;

  // Register reset values.
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd2432;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd256;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd18099;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2
  } bpmd_reg_t;

  // Gain set seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } bpmd_gains_t;

  // Error stage payload.
  typedef struct packed {
    logic                     dead;
    logic                     weight;
    logic signed [ANGLE_W-1:0] err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W-1:0]   sum;
  } bpmd_err_t;

  // Product stage payload.
  typedef struct packed {
    logic                       dead;
    logic signed [PROD_P_W-1:0] p;
    logic signed [PROD_I_W-1:0] i;
    logic signed [PROD_D_W-1:0] d;
  } bpmd_prod_t;

  // Result item.
  typedef struct packed {
    logic [CMP_W-1:0] cmp_ch1;
    logic [CMP_W-1:0] cmp_ch2;
    logic [CMP_W-1:0] cmp_ch3;
    logic [CMP_W-1:0] cmp_ch4;
    logic [CMP_W-1:0] drive_level;
    logic             in_deadband;
  } bpmd_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpmd_if.sv =====
// Channel interfaces of the balance PID motor drive.
`default_nettype none

interface bpmd_in_if;
  import bpmd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ANGLE_W-1:0] tilt_angle;
  modport source (output valid, output tilt_angle, input ready);
  modport sink (input valid, input tilt_angle, output ready);
endinterface

interface bpmd_out_if;
  import bpmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] cmp_ch1;
  logic [CMP_W-1:0] cmp_ch2;
  logic [CMP_W-1:0] cmp_ch3;
  logic [CMP_W-1:0] cmp_ch4;
  logic [CMP_W-1:0] drive_level;
  logic             in_deadband;
  modport source (output valid, output cmp_ch1, output cmp_ch2, output cmp_ch3,
                  output cmp_ch4, output drive_level, output in_deadband, input ready);
  modport sink (input valid, input cmp_ch1, input cmp_ch2, input cmp_ch3,
                input cmp_ch4, input drive_level, input in_deadband, output ready);
endinterface

interface bpmd_cfg_if;
  import bpmd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bpmd_front.sv =====
// Input register, error forming, integral separation and controller state.
`default_nettype none

module bpmd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [bpmd_pkg::ANGLE_W-1:0] in_angle,
  output logic                           err_valid,
  input  logic                           err_ready,
  output bpmd_pkg::bpmd_err_t            err_data
);
  import bpmd_pkg::*;

  logic                      v0_r;
  logic signed [ANGLE_W-1:0] tilt_r;
  logic                      v1_r;
  bpmd_err_t                 st1_r;
  bpmd_err_t                 st1_nxt;
  logic signed [ANGLE_W-1:0] prev_error_r;
  logic signed [SUM_W-1:0]   error_sum_r;
  logic signed [SUM_W-1:0]   error_sum_nxt;

  logic                      ld1;
  logic signed [ANGLE_W:0]   neg_angle;
  logic signed [ANGLE_W-1:0] err;
  logic [ANGLE_W-1:0]        abs_err;
  logic [MAG_W-1:0]          mag;
  logic                      dead;
  logic                      above_limit;
  logic                      small_err;
  logic                      add_en;
  logic signed [SUM_W:0]     sum_wide;

  assign ld1      = !v1_r || err_ready;
  assign in_ready = !v0_r || ld1;

  // Error is the negated angle; the single unrepresentable case saturates.
  always_comb begin
    neg_angle = -{tilt_r[ANGLE_W-1], tilt_r};
    if (neg_angle > $signed({2'b00, {(ANGLE_W-1){1'b1}}})) begin
      err = {1'b0, {(ANGLE_W-1){1'b1}}};
    end else begin
      err = neg_angle[ANGLE_W-1:0];
    end
    abs_err     = err[ANGLE_W-1] ? ANGLE_W'(-err) : ANGLE_W'(err);
    mag         = abs_err[ANGLE_W-2:8];
    dead        = (mag == '0);
    above_limit = (mag > MAG_W'(SEPARATION_LIMIT));
    small_err   = (mag < MAG_W'(SEPARATION_LOWER));
    add_en      = !dead && !above_limit;
  end

  // Saturating integral update.
  always_comb begin
    sum_wide = {error_sum_r[SUM_W-1], error_sum_r}
             + {{(SUM_W-ANGLE_W+1){err[ANGLE_W-1]}}, err};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      error_sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      error_sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  // Payload for the product stage.
  always_comb begin
    st1_nxt.dead   = dead;
    st1_nxt.weight = small_err;
    st1_nxt.err    = err;
    st1_nxt.diff   = {err[ANGLE_W-1], err} - {prev_error_r[ANGLE_W-1], prev_error_r};
    st1_nxt.sum    = add_en ? error_sum_nxt : error_sum_r;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v0_r <= 1'b1;
    end else if (ld1) begin
      v0_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      tilt_r <= in_angle;
    end
  end

  // Error register and controller state; items pass here in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      prev_error_r <= '0;
      error_sum_r  <= '0;
    end else if (ld1) begin
      v1_r <= v0_r;
      if (v0_r && !dead) begin
        prev_error_r <= err;
      end
      if (v0_r && add_en) begin
        error_sum_r <= error_sum_nxt;
      end
    end
    if (ld1 && v0_r) begin
      st1_r <= st1_nxt;
    end
  end

  assign err_valid = v1_r;
  assign err_data  = st1_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpmd_mult.sv =====
// Gain multipliers for the proportional, integral and derivative terms.
`default_nettype none

module bpmd_mult (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bpmd_pkg::bpmd_gains_t  gains,
  input  logic                   err_valid,
  output logic                   err_ready,
  input  bpmd_pkg::bpmd_err_t    err_data,
  output logic                   prod_valid,
  input  logic                   prod_ready,
  output bpmd_pkg::bpmd_prod_t   prod_data
);
  import bpmd_pkg::*;

  logic                       v2_r;
  bpmd_prod_t                 st2_r;
  bpmd_prod_t                 st2_nxt;
  logic signed [GAIN_W:0]     kp_s;
  logic signed [GAIN_W:0]     ki_s;
  logic signed [GAIN_W:0]     kd_s;
  logic signed [PROD_I_W-1:0] prod_i;

  assign err_ready = !v2_r || prod_ready;

  // Three independent products; the integral term is gated by its weight.
  always_comb begin
    kp_s          = $signed({1'b0, gains.kp});
    ki_s          = $signed({1'b0, gains.ki});
    kd_s          = $signed({1'b0, gains.kd});
    st2_nxt.dead  = err_data.dead;
    st2_nxt.p     = kp_s * err_data.err;
    prod_i        = ki_s * err_data.sum;
    st2_nxt.i     = err_data.weight ? prod_i : '0;
    st2_nxt.d     = kd_s * err_data.diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (err_ready) begin
      v2_r <= err_valid;
    end
    if (err_ready && err_valid) begin
      st2_r <= st2_nxt;
    end
  end

  assign prod_valid = v2_r;
  assign prod_data  = st2_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpmd_drive.sv =====
// Term sum, truncation and clamping, compare values and the output register.
`default_nettype none

module bpmd_drive (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   prod_valid,
  output logic                   prod_ready,
  input  bpmd_pkg::bpmd_prod_t   prod_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output bpmd_pkg::bpmd_result_t res_data
);
  import bpmd_pkg::*;

  localparam logic signed [QUOT_W-1:0] DL_POS = QUOT_W'(DRIVE_LIMIT);
  localparam logic signed [QUOT_W-1:0] DL_NEG = -DL_POS;

  logic                    v3_r;
  logic                    dead3_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    v4_r;
  bpmd_result_t            res_r;
  bpmd_result_t            res_nxt;
  logic [CMP_W-1:0]        last_level_r;

  logic                     ld4;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] drv;
  logic                     drv_neg;
  logic [CMP_W-1:0]         mag;
  logic [CMP_W-1:0]         lvl_a;
  logic [CMP_W-1:0]         lvl_b;

  assign ld4        = !v4_r || res_ready;
  assign prod_ready = !v3_r || ld4;

  // Exact sum of the three terms in Q16.16.
  always_comb begin
    acc_nxt = ACC_W'(prod_data.p) + ACC_W'(prod_data.i) + ACC_W'(prod_data.d);
  end

  // Integer part truncated toward zero, then clamped.
  always_comb begin
    quot = acc_r[ACC_W-1:FRAC_W];
    if (acc_r[ACC_W-1] && (acc_r[FRAC_W-1:0] != '0)) begin
      quot = quot + QUOT_W'(1);
    end
    if (quot > DL_POS) begin
      drv = DL_POS;
    end else if (quot < DL_NEG) begin
      drv = DL_NEG;
    end else begin
      drv = quot;
    end
    drv_neg = drv[QUOT_W-1];
    mag     = drv_neg ? CMP_W'(-drv) : CMP_W'(drv);
    lvl_a   = CMP_W'({1'b0, mag} + (CMP_W+1)'(OFFSET_A));
    lvl_b   = CMP_W'({1'b0, mag} + (CMP_W+1)'(OFFSET_B));
  end

  // Result item; the deadband repeats the last level with all compares off.
  always_comb begin
    if (dead3_r) begin
      res_nxt.cmp_ch1     = '0;
      res_nxt.cmp_ch2     = '0;
      res_nxt.cmp_ch3     = '0;
      res_nxt.cmp_ch4     = '0;
      res_nxt.drive_level = last_level_r;
      res_nxt.in_deadband = 1'b1;
    end else begin
      res_nxt.cmp_ch1     = drv_neg ? lvl_a : '0;
      res_nxt.cmp_ch2     = drv_neg ? '0 : lvl_a;
      res_nxt.cmp_ch3     = drv_neg ? lvl_b : '0;
      res_nxt.cmp_ch4     = drv_neg ? '0 : lvl_b;
      res_nxt.drive_level = lvl_b;
      res_nxt.in_deadband = 1'b0;
    end
  end

  // Sum register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (prod_ready) begin
      v3_r <= prod_valid;
    end
    if (prod_ready && prod_valid) begin
      acc_r   <= acc_nxt;
      dead3_r <= prod_data.dead;
    end
  end

  // Output register and last reported level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r         <= 1'b0;
      last_level_r <= '0;
    end else if (ld4) begin
      v4_r <= v3_r;
      if (v3_r && !dead3_r) begin
        last_level_r <= lvl_b;
      end
    end
    if (ld4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = v4_r;
  assign res_data  = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/balance_pid_motor_drive.sv =====
// Top level of the balance PID motor drive with configuration registers.
`default_nettype none

// Takes one signed Q8.8 tilt angle per item and returns one item with four PWM
// compare values, the drive level and a deadband flag. The datapath is a
// five-register pipeline (input, error and integral state, gain products, term
// sum, output), and one item is accepted in every cycle while the output is not
// stalled; the rate is set by the error register, which updates the integral
// and the previous error as each item passes. Every stage has its own valid
// bit, so input ready falls only when all stages are full and the result is
// not taken. The gain registers (index 0 proportional, 1 integral, 2 derivative,
// unsigned Q8.8) always accept writes; writes to other indexes are ignored.

module balance_pid_motor_drive (
  input  logic        clk,
  input  logic        rst_n,
  bpmd_in_if.sink     in_chan,
  bpmd_out_if.source  out_chan,
  bpmd_cfg_if.sink    cfg_chan
);
  import bpmd_pkg::*;

  bpmd_gains_t  gains_r;
  logic         err_valid;
  logic         err_ready;
  bpmd_err_t    err_data;
  logic         prod_valid;
  logic         prod_ready;
  bpmd_prod_t   prod_data;
  bpmd_result_t res_data;

  // Gain registers.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kp <= PROP_GAIN_RST;
      gains_r.ki <= INTEG_GAIN_RST;
      gains_r.kd <= DERIV_GAIN_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_PROP_GAIN:  gains_r.kp <= cfg_chan.data;
        REG_INTEG_GAIN: gains_r.ki <= cfg_chan.data;
        REG_DERIV_GAIN: gains_r.kd <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  bpmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_angle  (in_chan.tilt_angle),
    .err_valid (err_valid),
    .err_ready (err_ready),
    .err_data  (err_data)
  );

  bpmd_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err_data   (err_data),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data)
  );

  bpmd_drive u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_data  (prod_data),
    .res_valid  (out_chan.valid),
    .res_ready  (out_chan.ready),
    .res_data   (res_data)
  );

  // Result item onto the output channel.
  assign out_chan.cmp_ch1     = res_data.cmp_ch1;
  assign out_chan.cmp_ch2     = res_data.cmp_ch2;
  assign out_chan.cmp_ch3     = res_data.cmp_ch3;
  assign out_chan.cmp_ch4     = res_data.cmp_ch4;
  assign out_chan.drive_level = res_data.drive_level;
  assign out_chan.in_deadband = res_data.in_deadband;

endmodule

`default_nettype wire

// ===== tb/sv/tb_balance_pid_motor_drive.sv =====
// Self-checking testbench of the balance PID motor drive with its own drive-law predictor.
module tb_balance_pid_motor_drive;
  timeunit 1ns;
  timeprecision 1ps;

  import bpmd_pkg::*;

  // Q8.8 scale and the limits of the 32-bit error integral.
  localparam int ONE_DEG = 256;
  localparam int SUM_MAX = 2147483647;
  localparam int SUM_MIN = -2147483647 - 1;
  // Largest error that is still added to the integral, negated as an angle.
  localparam int BAND_TOP_ANGLE = -(SEPARATION_LIMIT * ONE_DEG + ONE_DEG - 1);
  // Register index that the block has no register for.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Pipeline depth from accepted item to result, with some margin.
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  bpmd_in_if  in_chan ();
  bpmd_out_if out_chan ();
  bpmd_cfg_if cfg_chan ();

  balance_pid_motor_drive i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor copy of the gains and of the control state.
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  int                last_err;
  int                integ_sum;
  logic [CMP_W-1:0]  held_level;

  // Results still owed by the block, oldest first.
  bpmd_result_t expected_drives[$];
  int           fail_count;

  // Idling control of both channels.
  bit          idling;
  int unsigned stall_left;

  always #1 clk = ~clk;

  // Works out the result item of one tilt angle and advances the control state.
  function automatic bpmd_result_t compute_drive(logic signed [ANGLE_W-1:0] angle);
    bpmd_result_t res;
    int           err;
    int           mag;
    int           drive;
    int           m;
    bit           use_integ;
    longint       acc;
    longint       sum_next;
    res = '0;
    err = -int'(angle);
    // The negated most negative angle does not fit and saturates.
    if (err > 32767) err = 32767;
    mag = (err < 0 ? -err : err) >> 8;
    // Deadband: outputs off, the held level is repeated, state is kept.
    if (mag == 0) begin
      res.drive_level = held_level;
      res.in_deadband = 1'b1;
      return res;
    end
    // Integral separation: large errors neither use nor feed the integral.
    use_integ = (mag < SEPARATION_LOWER);
    if (mag <= SEPARATION_LIMIT) begin
      sum_next = longint'(integ_sum) + err;
      if (sum_next > SUM_MAX) sum_next = SUM_MAX;
      if (sum_next < SUM_MIN) sum_next = SUM_MIN;
      integ_sum = int'(sum_next);
    end
    acc = longint'(gain_p) * err + longint'(gain_d) * (err - last_err);
    if (use_integ) acc = acc + longint'(gain_i) * integ_sum;
    last_err = err;
    // Q16.16 to integer, truncated toward zero, then clamped.
    acc = acc / 65536;
    if (acc > DRIVE_LIMIT) acc = DRIVE_LIMIT;
    if (acc < -DRIVE_LIMIT) acc = -DRIVE_LIMIT;
    drive = int'(acc);
    // A drive of zero counts as forward.
    if (drive >= 0) begin
      m = drive;
      res.cmp_ch2 = CMP_W'(m + OFFSET_A);
      res.cmp_ch4 = CMP_W'(m + OFFSET_B);
    end else begin
      m = -drive;
      res.cmp_ch1 = CMP_W'(m + OFFSET_A);
      res.cmp_ch3 = CMP_W'(m + OFFSET_B);
    end
    held_level = CMP_W'(m + OFFSET_B);
    res.drive_level = held_level;
    return res;
  endfunction

  // Random angle, weighted toward the deadband and separation boundaries.
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int          mag;
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        mag = $urandom_range(0, ONE_DEG - 1);
      end
      1, 2, 3: begin
        mag = $urandom_range(ONE_DEG, SEPARATION_LOWER * ONE_DEG - 1);
      end
      4, 5: begin
        mag = $urandom_range(SEPARATION_LOWER * ONE_DEG, (SEPARATION_LIMIT + 1) * ONE_DEG - 1);
      end
      6: begin
        mag = $urandom_range((SEPARATION_LIMIT + 1) * ONE_DEG, 32768);
      end
      default: begin
        return r[ANGLE_W-1:0];
      end
    endcase
    return r[16] ? ANGLE_W'(mag) : ANGLE_W'(-mag);
  endfunction

  // Sends one angle item, with an optional idle burst first.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.tilt_angle <= angle;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_drives.push_back(compute_drive(angle));
  endtask

  // Writes one register; valid stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= data;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  gain_p = data;
      REG_INTEG_GAIN: gain_i = data;
      REG_DERIV_GAIN: gain_d = data;
      default: ;
    endcase
  endtask

  // Stops the angle stream and waits until every result has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
  endtask

  // Loads all three gains while the block is idle.
  task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd);
    drain_results();
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    cfg_chan.valid <= 1'b0;
  endtask

  // Boundaries of the deadband and of the separation band at reset gains.
  task automatic test_directed_cases();
    send_angle(16'sd0);
    send_angle(-16'sd256);
    send_angle(16'sd255);
    send_angle(-16'sd255);
    send_angle(16'sd256);
    send_angle(ANGLE_W'(-(SEPARATION_LOWER * ONE_DEG - 1)));
    send_angle(ANGLE_W'(-(SEPARATION_LOWER * ONE_DEG)));
    send_angle(ANGLE_W'(BAND_TOP_ANGLE));
    send_angle(ANGLE_W'(-(SEPARATION_LIMIT + 1) * ONE_DEG));
    send_angle(ANGLE_W'((SEPARATION_LIMIT + 1) * ONE_DEG));
    send_angle(ANGLE_W'(SEPARATION_LOWER * ONE_DEG));
    send_angle(-16'sd32768);
    send_angle(16'sd32767);
    send_angle(-16'sd32767);
    send_angle(16'sd0);
    send_angle(16'sd100);
    send_angle(-16'sd1);
    send_angle(16'sd1);
    // A write to an index without a register must change nothing.
    drain_results();
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_chan.valid <= 1'b0;
    send_angle(-16'sd1000);
    send_angle(16'sd3000);
    send_angle(16'sd10);
  endtask

  // All gains zero: every item outside the deadband drives forward at zero.
  task automatic test_zero_drive();
    set_gains(16'd0, 16'd0, 16'd0);
    send_angle(16'sd256);
    send_angle(-16'sd256);
    send_angle(16'sd32767);
    send_angle(-16'sd32768);
    send_angle(16'sd0);
  endtask

  // Random angles under several gain settings, extremes among them.
  task automatic test_random_gains();
    set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST);
    repeat (150) send_angle(pick_angle());
    set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (120) send_angle(pick_angle());
    set_gains(16'd0, 16'd0, 16'd0);
    repeat (40) send_angle(pick_angle());
    set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()));
    repeat (150) send_angle(pick_angle());
    // This stretch uses small gains and runs without idling.
    idling = 1'b0;
    set_gains(16'($urandom_range(0, 512)), 16'($urandom_range(0, 64)),
              16'($urandom_range(0, 512)));
    repeat (200) send_angle(pick_angle());
    idling = 1'b1;
    set_gains(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 256)),
              16'($urandom_range(0, 4096)));
    repeat (150) send_angle(pick_angle());
    set_gains(16'($urandom()), 16'($urandom_range(0, 16)), 16'd0);
    repeat (100) send_angle(pick_angle());
  endtask

  // Grows the integral from the top of the separation band, where it carries no
  // weight, then checks that it takes effect once the error is small again.
  task automatic test_integral_band();
    idling = 1'b0;
    set_gains(16'd0, 16'd1, 16'd0);
    repeat (40) send_angle(ANGLE_W'(BAND_TOP_ANGLE));
    send_angle(-16'sd256);
    send_angle(16'sd256);
    send_angle(ANGLE_W'(-(SEPARATION_LOWER * ONE_DEG - 1)));
    send_angle(ANGLE_W'(SEPARATION_LOWER * ONE_DEG - 1));
  endtask

  // Receiver side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compares every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    bpmd_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_drives.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want = expected_drives.pop_front();
        check_field("cmp_ch1", want.cmp_ch1, out_chan.cmp_ch1);
        check_field("cmp_ch2", want.cmp_ch2, out_chan.cmp_ch2);
        check_field("cmp_ch3", want.cmp_ch3, out_chan.cmp_ch3);
        check_field("cmp_ch4", want.cmp_ch4, out_chan.cmp_ch4);
        check_field("drive_level", want.drive_level, out_chan.drive_level);
        check_field("in_deadband", want.in_deadband, out_chan.in_deadband);
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #6_000_000;
    $display("tb_balance_pid_motor_drive: FAIL");
    $finish;
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.tilt_angle  = '0;
    out_chan.ready      = 1'b1;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = REG_PROP_GAIN;
    cfg_chan.data       = '0;
    stall_left          = 0;
    idling              = 1'b1;
    fail_count          = 0;
    gain_p              = PROP_GAIN_RST;
    gain_i              = INTEG_GAIN_RST;
    gain_d              = DERIV_GAIN_RST;
    last_err            = 0;
    integ_sum           = 0;
    held_level          = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_zero_drive();
    test_random_gains();
    test_integral_band();

    // Let the pipeline empty, within a bound.
    in_chan.valid <= 1'b0;
    for (int n = 0; n < 2000 && expected_drives.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_drives.size() != 0) begin
      $error("%0d result items never arrived", expected_drives.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_balance_pid_motor_drive: PASS");
    end else begin
      $display("tb_balance_pid_motor_drive: FAIL");
    end
    $finish;
  end

endmodule
